### sv/zbr_pkg.sv
// ---------------------------------------------------------------------------
// zbr_pkg: shared types and constants
// Screen size, reset values, palette and sequencer link types for the
// z-buffer point rasterizer.
// ---------------------------------------------------------------------------
package zbr_pkg;

  localparam int SCREEN_COLUMNS = 100;
  localparam int SCREEN_ROWS    = 40;
  localparam int CELLS          = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W         = $clog2(CELLS);

  localparam logic signed [15:0] BACKGROUND_DEPTH = 16'sd12800;
  localparam logic [6:0] EMPTY_CHAR = 7'd32;
  localparam logic [3:0] SHADE_MAX  = 4'd13;

  localparam logic [2:0] REG_CAMERA_X = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y = 3'd1;
  localparam logic [2:0] REG_CAMERA_Z = 3'd2;
  localparam logic [2:0] REG_FOV      = 3'd3;
  localparam logic [2:0] REG_LIGHT_X  = 3'd4;
  localparam logic [2:0] REG_LIGHT_Y  = 3'd5;
  localparam logic [2:0] REG_LIGHT_Z  = 3'd6;

  // Dividend width: |2*vx*fov + 12800*vz| < 2^52; doubled numerator < 2^54.
  localparam int NUM_W = 56;
  localparam int QUO_W = 40;

  // Request to the iterative divider.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;  // magnitude, non-negative
    logic [NUM_W-1:0] den;  // positive
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [6:0] palette_char(input logic [3:0] s);
    logic [6:0] c;
    case (s)
      4'd1:    c = 7'h2E; // .
      4'd2:    c = 7'h2C; // ,
      4'd3:    c = 7'h2D; // -
      4'd4:    c = 7'h7E; // ~
      4'd5:    c = 7'h3A; // :
      4'd6:    c = 7'h3B; // ;
      4'd7:    c = 7'h3D; // =
      4'd8:    c = 7'h21; // !
      4'd9:    c = 7'h3F; // ?
      4'd10:   c = 7'h23; // #
      4'd11:   c = 7'h24; // $
      4'd12:   c = 7'h26; // &
      4'd13:   c = 7'h40; // @
      4'd14:   c = 7'h4D; // M
      default: c = EMPTY_CHAR;
    endcase
    return c;
  endfunction

endpackage

### sv/zbr_divider.sv
// ---------------------------------------------------------------------------
// zbr_divider: restoring divider
// Unsigned long division, one quotient bit per cycle.
// Quotient must fit in QUO_W bits; callers drop results that are out of range.
// ---------------------------------------------------------------------------
module zbr_divider
  import zbr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [NUM_W:0]   trial;
  logic [NUM_W:0]   shifted;

  always_comb begin
    shifted = {rem, num[NUM_W-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
        // pre-align so QUO_W steps consume the low dividend bits
        rem  <= req.num >> QUO_W;
        num  <= req.num << (NUM_W - QUO_W);
        den  <= req.den;
        quo  <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (!trial[NUM_W]) begin
          rem <= trial[NUM_W-1:0];
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= shifted[NUM_W-1:0];
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo};

endmodule

### sv/zbr_store.sv
// ---------------------------------------------------------------------------
// zbr_store: depth and shade memory
// One port, registered read, 16-bit depth plus 4-bit shade per cell.
// ---------------------------------------------------------------------------
module zbr_store
  import zbr_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [19:0]       wdata,
  output logic [19:0]       rdata
);

  logic [19:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/zbuffer_point_rasterizer.sv
// ---------------------------------------------------------------------------
// zbuffer_point_rasterizer: z-buffered point splat with ASCII shading
// Projects points through one shared divider and one shared multiplier,
// keeps a depth and shade per screen cell, and reads cells back as chars.
// ---------------------------------------------------------------------------
//  channel  signals                           direction
//  in       in_valid/in_stall, req_type..row  input items
//  out      out_valid/out_stall, cell_char    one item per read
//  cfg      cfg_we, cfg_index, cfg_data       register writes
//
// A plot that reaches the store passes M0, M1, the column and row divides,
// RD, D0 to D2 and WR between accepts: two divides in the shared divider
// plus multiply and store steps in one shared 17x17 multiplier; dropped
// points leave early. An in-range read passes RDW and RDO. After reset the
// store is swept, one cell a cycle, and in_stall stays high meanwhile. A
// result waits in the output register under out_stall while the next plot
// item is accepted; a read item is held off until the register is empty.
// ---------------------------------------------------------------------------
module zbuffer_point_rasterizer
  import zbr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [6:0]         cell_column,
  input  logic [5:0]         cell_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         cell_char,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_M0    = 4'd2;  // vx*fov
  localparam logic [3:0] S_M1    = 4'd3;  // -vy*fov, start column divide
  localparam logic [3:0] S_DIVC  = 4'd4;
  localparam logic [3:0] S_DIVR  = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;  // store read issued
  localparam logic [3:0] S_D0    = 4'd7;  // dot terms
  localparam logic [3:0] S_D1    = 4'd8;
  localparam logic [3:0] S_D2    = 4'd9;
  localparam logic [3:0] S_D3    = 4'd10;
  localparam logic [3:0] S_WR    = 4'd11;
  localparam logic [3:0] S_RDW   = 4'd12; // read item: wait for data
  localparam logic [3:0] S_RDO   = 4'd13; // read item: emit and clear

  logic signed [15:0] camera_x, camera_y, camera_z, light_x, light_y, light_z;
  logic [15:0]        fov;

  logic [3:0]         state;
  logic [ADDR_W-1:0]  addr;
  logic               is_read;
  logic signed [16:0] vx, vy, vz;
  logic signed [15:0] pz;
  logic signed [15:0] nx, ny, nz;
  logic signed [33:0] pr;          // held product
  logic signed [NUM_W-1:0] num_c, num_r;
  logic               neg_r;
  logic [7:0]         col;
  logic signed [34:0] dot;
  logic               out_full;

  // shared multiplier: one signed 17x17 per cycle, combinational
  logic signed [16:0] ma, mb;
  logic signed [33:0] mp;
  assign mp = ma * mb;

  div_req_t dreq;
  div_rsp_t drsp;
  zbr_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic               we;
  logic [ADDR_W-1:0]  st_addr;
  logic [19:0]        wdata, rdata;
  zbr_store u_store (.clk(clk), .we(we), .addr(st_addr), .wdata(wdata), .rdata(rdata));

  // only a read item needs the output register
  assign in_stall = (state != S_IDLE) || (out_full && req_type);
  logic accept;
  assign accept = in_valid && !in_stall;

  // numerators, signed
  logic signed [NUM_W-1:0] vz_term_c, vz_term_r, den;
  assign vz_term_c = NUM_W'(vz) * NUM_W'(SCREEN_COLUMNS * 128);
  assign vz_term_r = NUM_W'(vz) * NUM_W'((SCREEN_ROWS / 2) * 256);
  assign den       = NUM_W'(vz) <<< 8;

  // round half away: q = (2|n| + d) / (2d)
  function automatic logic [NUM_W-1:0] rnum(input logic signed [NUM_W-1:0] n,
                                            input logic signed [NUM_W-1:0] d);
    logic [NUM_W-1:0] m;
    m = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
    return (m << 1) + NUM_W'(d);
  endfunction

  // a column/row result is in range only when positive and below the limit
  logic [QUO_W-1:0] q;
  assign q = drsp.quo;

  logic [3:0] shade;
  logic signed [38:0] sh13;
  always_comb begin
    sh13 = 39'(dot) * 39'sd13 + (39'sd1 <<< 27);
    if (dot <= 0) shade = 4'd0;
    else if ((sh13 >>> 28) > 39'sd13) shade = SHADE_MAX;
    else shade = 4'(sh13 >>> 28);
  end

  always_comb begin
    we      = 1'b0;
    st_addr = addr;
    wdata   = {BACKGROUND_DEPTH, 4'd0};
    case (state)
      S_CLEAR: we = 1'b1;
      S_WR: begin
        we    = 1'b1;
        wdata = {pz, shade + 4'd1};
      end
      S_RDO: we = !is_read ? 1'b0 : 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    ma = vx;
    mb = 17'($signed({1'b0, fov}));
    case (state)
      S_M1: ma = -vy;
      S_D0: begin ma = 17'(nx); mb = 17'(light_x); end
      S_D1: begin ma = 17'(ny); mb = 17'(light_y); end
      S_D2: begin ma = 17'(nz); mb = 17'(light_z); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= 16'sd0;
      camera_y <= -16'sd256;
      camera_z <= -16'sd6400;
      fov      <= 16'd10240;
      light_x  <= 16'sd9459;
      light_y  <= -16'sd9459;
      light_z  <= -16'sd9459;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAMERA_X: camera_x <= cfg_data;
        REG_CAMERA_Y: camera_y <= cfg_data;
        REG_CAMERA_Z: camera_z <= cfg_data;
        REG_FOV:      fov      <= cfg_data;
        REG_LIGHT_X:  light_x  <= cfg_data;
        REG_LIGHT_Y:  light_y  <= cfg_data;
        REG_LIGHT_Z:  light_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      out_full  <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (out_full && !out_stall) out_full <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (addr == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            is_read <= req_type;
            vx <= 17'(point_x) - 17'(camera_x);
            vy <= 17'(point_y) - 17'(camera_y);
            vz <= 17'(point_z) - 17'(camera_z);
            pz <= point_z;
            nx <= normal_x; ny <= normal_y; nz <= normal_z;
            if (req_type) begin
              if (cell_column < 7'(SCREEN_COLUMNS) && cell_row < 6'(SCREEN_ROWS)) begin
                addr  <= ADDR_W'(cell_row * SCREEN_COLUMNS + cell_column);
                state <= S_RDW;
              end else begin
                cell_char <= EMPTY_CHAR;
                out_full  <= 1'b1;
              end
            end else begin
              state <= S_M0;
            end
          end
        end
        S_M0: begin
          if (vz <= 0) state <= S_IDLE;
          else begin
            pr    <= mp;
            state <= S_M1;
          end
        end
        S_M1: begin
          num_c <= (NUM_W'(pr) <<< 1) + vz_term_c;
          num_r <= NUM_W'(mp) + vz_term_r;
          dreq.start <= 1'b1;
          dreq.num <= rnum((NUM_W'(pr) <<< 1) + vz_term_c, den);
          dreq.den <= NUM_W'(den) << 1;
          state <= S_DIVC;
        end
        S_DIVC: begin
          if (drsp.done) begin
            if (num_c[NUM_W-1] || q == 0 || q >= QUO_W'(SCREEN_COLUMNS)) state <= S_IDLE;
            else begin
              col <= 8'(q);
              dreq.start <= 1'b1;
              dreq.num <= rnum(num_r, den);
              dreq.den <= NUM_W'(den) << 1;
              neg_r <= num_r[NUM_W-1];
              state <= S_DIVR;
            end
          end
        end
        S_DIVR: begin
          if (drsp.done) begin
            if (neg_r || q == 0 || q >= QUO_W'(SCREEN_ROWS)) state <= S_IDLE;
            else begin
              addr  <= ADDR_W'(q[7:0] * SCREEN_COLUMNS + col);
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_D0;
        S_D0: begin
          // read data valid now; drop if not nearer
          if ($signed(pz) >= $signed(rdata[19:4])) state <= S_IDLE;
          else begin
            dot   <= 35'(mp);
            state <= S_D1;
          end
        end
        S_D1: begin dot <= dot + 35'(mp); state <= S_D2; end
        S_D2: begin dot <= dot + 35'(mp); state <= S_WR; end
        S_WR: state <= S_IDLE;
        S_RDW: state <= S_RDO;
        S_RDO: begin
          cell_char <= palette_char(rdata[3:0]);
          out_full  <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_full;

endmodule

### test/tb_zbuffer_point_rasterizer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_zbuffer_point_rasterizer: self-checking bench for the point rasterizer
// Drives plot and read items with random gaps and output stalls, keeps a
// shadow depth/shade screen to predict each read, and compares every char.
// ---------------------------------------------------------------------------
module tb_zbuffer_point_rasterizer;
  import zbr_pkg::*;

  typedef struct {
    logic               kind;
    logic signed [15:0] px, py, pz, nx, ny, nz;
    logic [6:0]         col;
    logic [5:0]         row;
  } req_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic signed [15:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic [6:0] cell_column = '0;
  logic [5:0] cell_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] cell_char;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  zbuffer_point_rasterizer DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the screen and registers
  logic signed [15:0] cam_x, cam_y, cam_z, li_x, li_y, li_z;
  logic [15:0] fov;
  logic signed [15:0] depth_map [CELLS];
  logic [3:0] shade_map [CELLS];

  req_item_t  pending_items[$];
  logic [6:0] expected_chars[$];
  req_item_t  drv_item;
  logic [6:0] drv_char;
  int errors = 0;
  bit calm = 0;          // no idling on either side
  bit hold_phase = 0;    // start the long receiver stall
  logic holding = 1'b0;  // receiver long stall in progress

  function automatic longint rdiv(longint n, longint d);
    if (n >= 0) return (2 * n + d) / (2 * d);
    return -((-2 * n + d) / (2 * d));
  endfunction

  // update the shadow screen; return the char for a read
  function automatic logic [6:0] rasterize(req_item_t it);
    longint vx, vy, vz, c, r, dp, sh;
    int idx;
    logic [6:0] ch;
    ch = EMPTY_CHAR;
    if (!it.kind) begin
      vx = longint'(it.px) - cam_x;
      vy = longint'(it.py) - cam_y;
      vz = longint'(it.pz) - cam_z;
      if (vz <= 0) return ch;
      c = rdiv(2 * vx * longint'(fov) + SCREEN_COLUMNS * 128 * vz, 256 * vz);
      r = rdiv(-vy * longint'(fov) + (SCREEN_ROWS / 2) * 256 * vz, 256 * vz);
      if (c <= 0 || c >= SCREEN_COLUMNS || r <= 0 || r >= SCREEN_ROWS) return ch;
      idx = int'(r * SCREEN_COLUMNS + c);
      if (it.pz >= depth_map[idx]) return ch;
      dp = longint'(it.nx) * li_x + longint'(it.ny) * li_y + longint'(it.nz) * li_z;
      if (dp <= 0) sh = 0;
      else begin
        sh = (13 * dp + (64'sd1 <<< 27)) >>> 28;
        if (sh > 13) sh = 13;
      end
      depth_map[idx] = it.pz;
      shade_map[idx] = 4'(sh + 1);
    end else if (it.col < SCREEN_COLUMNS && it.row < SCREEN_ROWS) begin
      idx = it.row * SCREEN_COLUMNS + it.col;
      case (shade_map[idx])
        1: ch = ".";   2: ch = ",";   3: ch = "-";   4: ch = "~";
        5: ch = ":";   6: ch = ";";   7: ch = "=";   8: ch = "!";
        9: ch = "?";   10: ch = "#";  11: ch = "$";  12: ch = "&";
        13: ch = "@";  14: ch = "M";  default: ch = EMPTY_CHAR;
      endcase
      shade_map[idx] = 0;
      depth_map[idx] = BACKGROUND_DEPTH;
    end
    return ch;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        drv_item = pending_items.pop_front();
        drv_char = rasterize(drv_item);
        // only a read item produces a result
        if (drv_item.kind) expected_chars.push_back(drv_char);
      end
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
        in_valid    <= 1'b1;
        req_type    <= pending_items[0].kind;
        point_x     <= pending_items[0].px;
        point_y     <= pending_items[0].py;
        point_z     <= pending_items[0].pz;
        normal_x    <= pending_items[0].nx;
        normal_y    <= pending_items[0].ny;
        normal_z    <= pending_items[0].nz;
        cell_column <= pending_items[0].col;
        cell_row    <= pending_items[0].row;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected cell_char %0d", $time, cell_char);
          errors++;
        end else begin
          if (cell_char !== expected_chars[0]) begin
            $display("%0t: cell_char expected %0d actual %0d", $time,
                     expected_chars[0], cell_char);
            errors++;
          end
          void'(expected_chars.pop_front());
        end
      end
      out_stall <= holding || (!calm && ($urandom_range(99) < 12));
    end
  end

  // long receiver stall, counted in cycles
  initial begin
    wait (hold_phase);
    @(posedge clk);
    holding <= 1'b1;
    repeat (2000) @(posedge clk);
    holding <= 1'b0;
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAMERA_X: cam_x = v;
      REG_CAMERA_Y: cam_y = v;
      REG_CAMERA_Z: cam_z = v;
      REG_FOV:      fov = v;
      REG_LIGHT_X:  li_x = v;
      REG_LIGHT_Y:  li_y = v;
      default:      li_z = v;
    endcase
  endtask

  task automatic settle();
    wait (pending_items.size() == 0 && !in_valid && expected_chars.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic req_item_t make_read(int c, int r);
    req_item_t it;
    it = '{1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), 7'(c), 6'(r)};
    return it;
  endfunction

  function automatic logic signed [15:0] unit_rand();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // plot aimed near the camera center so most points land on screen
  function automatic req_item_t make_plot();
    req_item_t it;
    it.kind = 1'b0;
    it.px = 16'(cam_x + $signed($urandom_range(1600)) - 800);
    it.py = 16'(cam_y + $signed($urandom_range(1600)) - 800);
    it.pz = 16'(cam_z + $signed($urandom_range(6000)) + 500);
    it.nx = unit_rand(); it.ny = unit_rand(); it.nz = unit_rand();
    it.col = 7'($urandom); it.row = 6'($urandom);
    if ($urandom_range(9) == 0) begin
      it.px = 16'($urandom); it.py = 16'($urandom); it.pz = 16'($urandom);
    end
    return it;
  endfunction

  // random phase: plots mixed with reads, mostly of the neighborhood the plots hit
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55) pending_items.push_back(make_plot());
      else if ($urandom_range(19) == 0)
        pending_items.push_back(make_read($urandom_range(127), $urandom_range(63)));
      else
        pending_items.push_back(make_read($urandom_range(35, 64), $urandom_range(10, 30)));
    end
  endtask

  initial begin
    req_item_t it;
    cam_x = 0; cam_y = -256; cam_z = -6400; fov = 10240;
    li_x = 9459; li_y = -9459; li_z = -9459;
    foreach (depth_map[i]) begin
      depth_map[i] = BACKGROUND_DEPTH;
      shade_map[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: center point, tie, nearer, behind camera, edges, out-of-range reads
    it = '{1'b0, 16'sd0, -16'sd256, 16'sd0, 16'sd9459, -16'sd9459, -16'sd9459, 7'd0, 6'd0};
    pending_items.push_back(it);                        // full light, cell 20,50
    pending_items.push_back(it);                        // depth tie: dropped
    it.pz = -16'sd256; it.nx = -16'sd16384; it.ny = 0; it.nz = 0;
    pending_items.push_back(it);                        // nearer, shade 0
    pending_items.push_back(make_read(50, 20));
    it.pz = -16'sd6400; pending_items.push_back(it);    // vz zero
    it.pz = 16'sh8000; pending_items.push_back(it);     // behind
    it.pz = 16'sh7FFF; it.px = 16'sh7FFF; pending_items.push_back(it); // off right
    it.px = 16'sh8000; it.py = 16'sh7FFF; pending_items.push_back(it);
    it.px = 0; it.py = -16'sd256; it.pz = 0; it.nx = 16'sd16384;
    it.ny = -16'sd16384; it.nz = -16'sd16384; it.col = 7'h7F; it.row = 6'h3F;
    pending_items.push_back(it);                        // saturating shade
    pending_items.push_back(make_read(50, 20));
    pending_items.push_back(make_read(50, 20));         // cleared: space
    pending_items.push_back(make_read(127, 63));
    pending_items.push_back(make_read(99, 39));
    pending_items.push_back(make_read(100, 0));
    pending_items.push_back(make_read(0, 40));
    pending_items.push_back(make_read(0, 0));
    settle();

    // reset values are the first setting; then extremes and random ones
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 1) begin
        write_reg(REG_CAMERA_X, 16'sh8000); write_reg(REG_CAMERA_Y, 16'sh7FFF);
        write_reg(REG_CAMERA_Z, 16'sh8000); write_reg(REG_FOV, 16'hFFFF);
        write_reg(REG_LIGHT_X, 16'sd16384); write_reg(REG_LIGHT_Y, -16'sd16384);
        write_reg(REG_LIGHT_Z, 16'sd16384);
      end else if (ph == 2) begin
        write_reg(REG_CAMERA_X, 16'sh7FFF); write_reg(REG_CAMERA_Y, 16'sh8000);
        write_reg(REG_CAMERA_Z, 16'sh7FFF); write_reg(REG_FOV, 16'h0000);
        write_reg(REG_LIGHT_X, -16'sd16384); write_reg(REG_LIGHT_Y, 16'sd16384);
        write_reg(REG_LIGHT_Z, -16'sd16384);
      end else if (ph > 2) begin
        write_reg(REG_CAMERA_X, 16'($urandom_range(4000) - 2000));
        write_reg(REG_CAMERA_Y, 16'($urandom_range(4000) - 2000));
        write_reg(REG_CAMERA_Z, 16'($urandom_range(4000) - 8000));
        write_reg(REG_FOV, 16'($urandom_range(2000, 20000)));
        write_reg(REG_LIGHT_X, unit_rand()); write_reg(REG_LIGHT_Y, unit_rand());
        write_reg(REG_LIGHT_Z, unit_rand());
      end
      calm = (ph == 4);
      if (ph == 5) hold_phase = 1;
      random_phase(125);
      settle();
    end

    if (errors == 0) $display("zbuffer_point_rasterizer: match");
    else $display("zbuffer_point_rasterizer: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("zbuffer_point_rasterizer: mismatch");
    $finish;
  end

endmodule
